// ----- rtl/core/bfbs_pkg.sv -----
// Shared types, codes and constants for the best-fit block suballocator.
package bfbs_pkg;

	// Fixed field widths.
	localparam int ADDR_W = 32;
	localparam int ALIGN_W = 5;
	localparam int STATUS_W = 2;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 32;

	// Reset values of the configuration registers.
	localparam logic [ADDR_W-1:0] HEAP_SIZE_RESET = 32'd4194304;
	localparam logic [ALIGN_W-1:0] GRANULE_LOG2_RESET = 5'd12;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_HEAP_SIZE = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_GRANULE_LOG2 = 1'b1;

	// Operation codes.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;

	// Status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOFIT = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_BADFREE = 2'd3;

	// Drain counter width and the counter value that ends the pipeline drain.
	localparam int DRAIN_W = 2;
	localparam logic [DRAIN_W-1:0] DRAIN_LAST = 2'd2;

	typedef struct packed {
		logic operation;
		logic [ADDR_W-1:0] request_size;
		logic [ALIGN_W-1:0] align_log2;
		logic [ADDR_W-1:0] block_offset;
		logic [ADDR_W-1:0] block_length;
	} bfbs_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0] grant_offset;
		logic [ADDR_W-1:0] grant_size;
	} bfbs_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_PREP,
		ST_COMMIT
	} bfbs_state_t;

	typedef struct packed {
		logic load;
		logic issue;
		logic prep;
		logic commit;
	} bfbs_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic rsp_free;
	} bfbs_sts_t;

endpackage

// ----- rtl/core/bfbs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bfbs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/bfbs_ctrl.sv -----
// Sequencing state machine for the best-fit block suballocator.
module bfbs_ctrl import bfbs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  bfbs_sts_t sts,
	output bfbs_cmd_t cmd
);

	bfbs_state_t state_q, state_d;
	logic [DRAIN_W-1:0] drain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			drain_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DRAIN) begin
				drain_q <= drain_q + 1'b1;
			end else begin
				drain_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_q == DRAIN_LAST) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (sts.rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				cmd.load = req_valid;
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
			end
			ST_COMMIT: begin
				cmd.commit = sts.rsp_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ----- rtl/core/bfbs_datapath.sv -----
// Free-range table, scan pipeline, update logic and response register.
module bfbs_datapath import bfbs_pkg::*; #(
	parameter int FREE_ENTRIES = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  bfbs_req_t              req,
	input  bfbs_cmd_t              cmd,
	output bfbs_sts_t              sts,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output bfbs_rsp_t              rsp
);

	localparam int IW = $clog2(FREE_ENTRIES);
	localparam int EW = 2 * ADDR_W;

	// Configuration and table bookkeeping.
	logic [ADDR_W-1:0]       heap_size_q;
	logic [ALIGN_W-1:0]      gran_q;
	logic                    whole_q;
	logic [FREE_ENTRIES-1:0] valid_q;

	// Request held for the duration of the transaction.
	logic              op_q;
	logic              size_zero_q;
	logic [ADDR_W:0]   sizeg_q;
	logic [ADDR_W:0]   amask_q;
	logic [ADDR_W+2:0] gmask_q;
	logic [ADDR_W-1:0] off_q;
	logic [ADDR_W-1:0] len_q;
	logic [ADDR_W:0]   fend_q;
	logic [IW-1:0]     cnt_q;

	// Scan pipeline.
	logic              act_s1, ev_s1;
	logic [IW-1:0]     idx_s1;
	logic              act_s2, ev_s2;
	logic [IW-1:0]     idx_s2;
	logic [ADDR_W-1:0] s_s2, l_s2;
	logic [ADDR_W:0]   off_s2, lim_s2;
	logic              act_s3, ev_s3;
	logic [IW-1:0]     idx_s3;
	logic [ADDR_W-1:0] s_s3, l_s3;
	logic [ADDR_W:0]   off_s3, lim_s3;
	logic [ADDR_W+2:0] end_s3;

	// Scan results.
	logic              best_found_q;
	logic [IW-1:0]     best_idx_q;
	logic [ADDR_W-1:0] best_s_q, best_l_q;
	logic [ADDR_W:0]   best_end_q, best_off_q, best_lim_q;
	logic              bad_q;
	logic              bef_found_q, aft_found_q, emp_found_q;
	logic [IW-1:0]     bef_idx_q, aft_idx_q, emp_idx_q;
	logic [ADDR_W-1:0] bef_s_q, bef_l_q, aft_l_q;

	// Prepared update.
	logic [STATUS_W-1:0] st_q;
	logic                keep_q;
	logic [ADDR_W-1:0]   newlen_q, gsize_q, merge_q;

	logic      rsp_valid_q;
	bfbs_rsp_t rsp_q;

	// Combinational signals.
	logic [EW-1:0]     ram_rdata, ram_wdata;
	logic              ram_we;
	logic [IW-1:0]     ram_waddr;
	logic [ADDR_W-1:0] rd_start, rd_len;
	logic [ADDR_W:0]   rd_off, rd_lim;
	logic [ADDR_W+2:0] sum_end;
	logic              fit, better, overlap;
	logic              clr_en, set_en;
	logic [IW-1:0]     clr_idx, set_idx;
	logic              ok;
	logic [ADDR_W+2:0] gmask_d;
	logic [ADDR_W:0]   amask_d;
	logic [ADDR_W:0]   keep_diff;
	logic              prebad;

	bfbs_ram #(
		.WIDTH(EW),
		.DEPTH(FREE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(cnt_q),
		.rdata(ram_rdata)
	);

	// Entry 0 reads as the whole heap until it is first rewritten.
	always_comb begin
		if (whole_q && idx_s1 == '0) begin
			rd_start = '0;
			rd_len = heap_size_q;
		end else begin
			rd_start = ram_rdata[EW-1:ADDR_W];
			rd_len = ram_rdata[ADDR_W-1:0];
		end
		rd_lim = {1'b0, rd_start} + {1'b0, rd_len};
		if (rd_start == '0) begin
			rd_off = '0;
		end else begin
			rd_off = ({1'b0, rd_start} + amask_q) & ~amask_q;
		end
	end

	assign sum_end = ({2'b0, off_s2} + {2'b0, sizeg_q}) & ~gmask_q;

	assign fit = end_s3 <= {2'b0, lim_s3};
	assign better = !best_found_q || (l_s3 < best_l_q) ||
		((l_s3 == best_l_q) && (s_s3 < best_s_q));
	assign overlap = ({1'b0, off_q} < lim_s3) && ({1'b0, s_s3} < fend_q);

	assign gmask_d = (35'd1 << gran_q) - 35'd1;
	assign amask_d = (33'd1 << req.align_log2) - 33'd1;
	assign keep_diff = best_lim_q - best_end_q;
	assign prebad = (len_q == '0) || (fend_q > {1'b0, heap_size_q}) || bad_q;

	// Table write for the committed update.
	assign ok = st_q == STATUS_OK;
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = best_idx_q;
		ram_wdata = {best_end_q[ADDR_W-1:0], newlen_q};
		clr_en = 1'b0;
		clr_idx = best_idx_q;
		set_en = 1'b0;
		set_idx = emp_idx_q;
		if (cmd.commit && ok) begin
			if (op_q == OP_ALLOC) begin
				if (keep_q) begin
					ram_we = 1'b1;
				end else begin
					clr_en = 1'b1;
				end
			end else if (bef_found_q) begin
				ram_we = 1'b1;
				ram_waddr = bef_idx_q;
				ram_wdata = {bef_s_q, bef_l_q + merge_q};
				clr_en = aft_found_q;
				clr_idx = aft_idx_q;
			end else begin
				ram_we = 1'b1;
				ram_waddr = aft_found_q ? aft_idx_q : emp_idx_q;
				ram_wdata = {off_q, merge_q};
				set_en = !aft_found_q;
			end
		end
	end

	// Configuration, valid bits and whole-heap marker.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_size_q <= HEAP_SIZE_RESET;
			gran_q <= GRANULE_LOG2_RESET;
			whole_q <= 1'b1;
			valid_q <= FREE_ENTRIES'(1);
		end else if (cfg_we) begin
			if (cfg_index == CFG_HEAP_SIZE) begin
				heap_size_q <= cfg_wdata;
				whole_q <= 1'b1;
				valid_q <= (cfg_wdata != '0) ? FREE_ENTRIES'(1) : '0;
			end else begin
				gran_q <= cfg_wdata[ALIGN_W-1:0];
			end
		end else begin
			if (ram_we && ram_waddr == '0) begin
				whole_q <= 1'b0;
			end
			if (clr_en) begin
				valid_q[clr_idx] <= 1'b0;
			end
			if (set_en) begin
				valid_q[set_idx] <= 1'b1;
			end
		end
	end

	// Request capture and scan address.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= req.operation;
			size_zero_q <= req.request_size == '0;
			sizeg_q <= {1'b0, req.request_size} + gmask_d[ADDR_W:0];
			amask_q <= amask_d;
			gmask_q <= gmask_d;
			off_q <= req.block_offset;
			len_q <= req.block_length;
			fend_q <= {1'b0, req.block_offset} + {1'b0, req.block_length};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			act_s1 <= 1'b0;
			act_s2 <= 1'b0;
			act_s3 <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			act_s1 <= cmd.issue;
			act_s2 <= act_s1;
			act_s3 <= act_s2;
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		ev_s1 <= valid_q[cnt_q];
		idx_s1 <= cnt_q;
		ev_s2 <= ev_s1;
		idx_s2 <= idx_s1;
		s_s2 <= rd_start;
		l_s2 <= rd_len;
		off_s2 <= rd_off;
		lim_s2 <= rd_lim;
		ev_s3 <= ev_s2;
		idx_s3 <= idx_s2;
		s_s3 <= s_s2;
		l_s3 <= l_s2;
		off_s3 <= off_s2;
		lim_s3 <= lim_s2;
		end_s3 <= sum_end;
	end

	// Evaluation of one entry per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_found_q <= 1'b0;
			bad_q <= 1'b0;
			bef_found_q <= 1'b0;
			aft_found_q <= 1'b0;
			emp_found_q <= 1'b0;
		end else if (cmd.load) begin
			best_found_q <= 1'b0;
			bad_q <= 1'b0;
			bef_found_q <= 1'b0;
			aft_found_q <= 1'b0;
			emp_found_q <= 1'b0;
		end else if (act_s3) begin
			if (op_q == OP_ALLOC) begin
				if (ev_s3 && fit && better) begin
					best_found_q <= 1'b1;
				end
			end else if (ev_s3) begin
				if (overlap) begin
					bad_q <= 1'b1;
				end
				if (lim_s3 == {1'b0, off_q}) begin
					bef_found_q <= 1'b1;
				end
				if ({1'b0, s_s3} == fend_q) begin
					aft_found_q <= 1'b1;
				end
			end else begin
				emp_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (act_s3) begin
			if (op_q == OP_ALLOC) begin
				if (ev_s3 && fit && better) begin
					best_idx_q <= idx_s3;
					best_s_q <= s_s3;
					best_l_q <= l_s3;
					best_end_q <= end_s3[ADDR_W:0];
					best_off_q <= off_s3;
					best_lim_q <= lim_s3;
				end
			end else if (ev_s3) begin
				if (lim_s3 == {1'b0, off_q}) begin
					bef_idx_q <= idx_s3;
					bef_s_q <= s_s3;
					bef_l_q <= l_s3;
				end
				if ({1'b0, s_s3} == fend_q) begin
					aft_idx_q <= idx_s3;
					aft_l_q <= l_s3;
				end
			end else if (!emp_found_q) begin
				emp_idx_q <= idx_s3;
			end
		end
	end

	// Final status and update values.
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			if (op_q == OP_ALLOC) begin
				st_q <= (size_zero_q || !best_found_q) ? STATUS_NOFIT : STATUS_OK;
			end else if (prebad) begin
				st_q <= STATUS_BADFREE;
			end else if (!bef_found_q && !aft_found_q && !emp_found_q) begin
				st_q <= STATUS_FULL;
			end else begin
				st_q <= STATUS_OK;
			end
			keep_q <= best_lim_q > best_end_q;
			newlen_q <= keep_diff[ADDR_W-1:0];
			gsize_q <= best_end_q[ADDR_W-1:0] - best_off_q[ADDR_W-1:0];
			merge_q <= len_q + (aft_found_q ? aft_l_q : '0);
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q.status <= st_q;
			if (ok && op_q == OP_ALLOC) begin
				rsp_q.grant_offset <= best_off_q[ADDR_W-1:0];
				rsp_q.grant_size <= gsize_q;
			end else begin
				rsp_q.grant_offset <= '0;
				rsp_q.grant_size <= '0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
	assign sts.scan_last = cnt_q == IW'(FREE_ENTRIES - 1);
	assign sts.rsp_free = !rsp_valid_q || !rsp_stall;

endmodule

// ----- rtl/core/best_fit_block_suballocator_unit.sv -----
// Top level of the best-fit block suballocator: controller, datapath and ports.
//
// This block hands out and takes back blocks of one heap, keeping the free space as a
// table of FREE_ENTRIES ranges (start, length). After reset, and after every write of
// the heap_size register, the table holds the single range [0, heap_size), or nothing
// when heap_size is zero. An allocate transaction aligns each free range's start up to
// 2^align_log2 (a start of zero stays zero), rounds the end up to 2^granule_log2, and
// picks the smallest range that fits, lowest start on a tie; the granted offset and
// size come back with status ok, and the range loses everything up to the rounded end,
// including the alignment padding. A free transaction merges the block with the free
// ranges that end at its start and begin at its end, or takes an empty table entry;
// it reports a full table, or an inconsistent free when the length is zero, the block
// runs past heap_size, or it overlaps free space. A failed transaction changes nothing
// and returns zero offset and size. The table sits in one RAM with a single read port,
// so the scan reads one entry per cycle, followed by a pipeline drain, a state that
// prepares the update and one that commits it; a new request is taken only once the
// previous one is committed. The finished response waits in an output register, so
// the next request is taken while it is still stalled; a new response is only
// committed once that register is free. Configuration writes are to be issued only
// while no transaction is in flight.
module best_fit_block_suballocator_unit import bfbs_pkg::*; #(
	parameter int FREE_ENTRIES = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  bfbs_req_t              req,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output bfbs_rsp_t              rsp
);

	// Commands from the controller and status back from the datapath.
	bfbs_cmd_t cmd;
	bfbs_sts_t sts;

	// The controller sequences accept, scan, drain, prepare and commit.
	bfbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath owns the free table, the configuration registers and the response.
	bfbs_datapath #(
		.FREE_ENTRIES(FREE_ENTRIES)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule
